// ===== hdl/tmms_pkg.sv =====
// types and constants shared by the trimmed mean / min / max / sum core
// no dependencies
package tmms_pkg;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic signed [47:0] total;
    logic [15:0]        item_total;
    logic signed [39:0] trimmed_mean;
    logic [1:0]         status;
  } out_item_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_OVER  = 2'd2;

  localparam int MEAN_W = 40;
  localparam logic [MEAN_W-1:0] MEAN_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [MEAN_W-1:0] MEAN_MIN = 40'h80_0000_0000;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NUM,
    BK_PREP,
    BK_DIV,
    BK_FINISH
  } back_state_t;

endpackage

// ===== hdl/tmms_front.sv =====
// front end: takes samples, keeps count, min, max and sum of the current run
// emits one run record on the last item; uses tmms_pkg
module tmms_front #(
  parameter int MAX_ITEMS = 65535,
  parameter int CNT_W     = 16,
  parameter int SUM_W     = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  tmms_pkg::in_item_t       item,
  output logic                     rec_push,
  output logic signed [31:0]       rec_min,
  output logic signed [31:0]       rec_max,
  output logic signed [SUM_W-1:0]  rec_sum,
  output logic [CNT_W-1:0]         rec_cnt,
  output logic [1:0]               rec_status
);
  import tmms_pkg::*;

  logic [CNT_W-1:0]        count_r, count_nxt, count_upd;
  logic signed [31:0]      min_r, min_nxt, min_upd;
  logic signed [31:0]      max_r, max_nxt, max_upd;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_upd;
  logic                    ovf_r, ovf_nxt, ovf_upd;
  logic                    first;

  always_comb begin
    first     = (count_r == '0);
    count_upd = count_r;
    min_upd   = min_r;
    max_upd   = max_r;
    sum_upd   = sum_r;
    ovf_upd   = ovf_r;
    if (count_r != CNT_W'(MAX_ITEMS)) begin
      count_upd = count_r + CNT_W'(1);
      min_upd   = (first || item.sample < min_r) ? item.sample : min_r;
      max_upd   = (first || item.sample > max_r) ? item.sample : max_r;
      sum_upd   = sum_r + SUM_W'(item.sample);
    end else begin
      ovf_upd = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    ovf_nxt   = ovf_r;
    if (take) begin
      if (item.last) begin
        count_nxt = '0;
        min_nxt   = '0;
        max_nxt   = '0;
        sum_nxt   = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_upd;
        min_nxt   = min_upd;
        max_nxt   = max_upd;
        sum_nxt   = sum_upd;
        ovf_nxt   = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      sum_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    rec_push = take && item.last;
    rec_min  = min_upd;
    rec_max  = max_upd;
    rec_sum  = sum_upd;
    rec_cnt  = count_upd;
    priority if (ovf_upd) begin
      rec_status = STATUS_OVER;
    end else if (count_upd < CNT_W'(3)) begin
      rec_status = STATUS_SHORT;
    end else begin
      rec_status = STATUS_OK;
    end
  end

endmodule

// ===== hdl/tmms_fifo.sv =====
// two-entry queue of run records between front and back end
// no dependencies
module tmms_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   fill_r, fill_nxt;
  logic         do_push, do_pop;

  always_comb begin
    full       = (fill_r == 2'd2);
    empty      = (fill_r == 2'd0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    dout       = entry_r[rd_ptr_r];
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== hdl/tmms_back.sv =====
// back end: trimmed mean by bit-serial restoring division, result register
// uses tmms_pkg
module tmms_back #(
  parameter int FRAC_BITS = 8,
  parameter int CNT_W     = 16,
  parameter int SUM_W     = 48,
  parameter int REC_W     = 130
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rec_empty,
  input  logic [REC_W-1:0]      rec_data,
  output logic                  rec_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output tmms_pkg::out_item_t   out_item
);
  import tmms_pkg::*;

  localparam int NUM_W = SUM_W + 2;
  localparam int MAG_W = SUM_W + 1;
  localparam int DW    = MAG_W + FRAC_BITS;
  localparam int BC_W  = $clog2(DW + 1);
  localparam int QX_W  = (DW > MEAN_W + 1) ? DW : MEAN_W + 1;
  localparam int ITW   = (CNT_W > 16) ? CNT_W : 16;

  back_state_t state_r, state_nxt;

  logic signed [31:0]      min_r, max_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        cnt_r, den_r;
  logic [1:0]              status_r;
  logic signed [NUM_W-1:0] num_r;
  logic                    neg_r;
  logic [DW-1:0]           quo_r;
  logic [CNT_W-1:0]        rem_r;
  logic [BC_W-1:0]         bit_cnt_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r;

  logic                    load_rec, do_num, do_prep, do_step, do_out;
  logic [MAG_W-1:0]        mag;
  logic [NUM_W-1:0]        num_neg;
  logic [CNT_W:0]          shifted;
  logic                    ge;
  logic [QX_W-1:0]         qx, qx_neg;
  logic signed [39:0]      mean;
  logic [ITW-1:0]          cnt_x;
  out_item_t               result;
  logic                    out_free;

  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!rec_empty) begin
          state_nxt = (rec_data[1:0] == STATUS_OK) ? BK_NUM : BK_FINISH;
        end
      end
      BK_NUM:  state_nxt = BK_PREP;
      BK_PREP: state_nxt = BK_DIV;
      BK_DIV: begin
        if (bit_cnt_r == BC_W'(DW - 1)) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load_rec = 1'b0;
    do_num   = 1'b0;
    do_prep  = 1'b0;
    do_step  = 1'b0;
    do_out   = 1'b0;
    unique case (state_r)
      BK_IDLE:   load_rec = !rec_empty;
      BK_NUM:    do_num   = 1'b1;
      BK_PREP:   do_prep  = 1'b1;
      BK_DIV:    do_step  = 1'b1;
      BK_FINISH: do_out   = out_free;
      default:   load_rec = 1'b0;
    endcase
    rec_pop = load_rec;
  end

  // datapath
  always_comb begin
    num_neg = -num_r;
    mag     = num_r[NUM_W-1] ? num_neg[MAG_W-1:0] : num_r[MAG_W-1:0];
    shifted = {rem_r, quo_r[DW-1]};
    ge      = (shifted >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (load_rec) begin
      min_r    <= rec_data[REC_W-1 -: 32];
      max_r    <= rec_data[REC_W-33 -: 32];
      sum_r    <= rec_data[REC_W-65 -: SUM_W];
      cnt_r    <= rec_data[CNT_W+1:2];
      status_r <= rec_data[1:0];
    end
    if (do_num) begin
      num_r <= NUM_W'(sum_r) - NUM_W'(min_r) - NUM_W'(max_r);
    end
    if (do_prep) begin
      neg_r     <= num_r[NUM_W-1];
      quo_r     <= DW'(mag) << FRAC_BITS;
      rem_r     <= '0;
      den_r     <= cnt_r - CNT_W'(2);
      bit_cnt_r <= '0;
    end
    if (do_step) begin
      rem_r     <= ge ? CNT_W'(shifted - {1'b0, den_r}) : shifted[CNT_W-1:0];
      quo_r     <= {quo_r[DW-2:0], ge};
      bit_cnt_r <= bit_cnt_r + BC_W'(1);
    end
    if (do_out) begin
      out_item_r <= result;
    end
  end

  always_comb begin
    qx     = QX_W'(quo_r);
    qx_neg = -qx;
    if (status_r != STATUS_OK) begin
      mean = '0;
    end else if (neg_r) begin
      mean = (qx > QX_W'(64'h0000_0080_0000_0000)) ? MEAN_MIN : qx_neg[MEAN_W-1:0];
    end else begin
      mean = (qx > QX_W'(64'h0000_007F_FFFF_FFFF)) ? MEAN_MAX : qx[MEAN_W-1:0];
    end
    cnt_x               = ITW'(cnt_r);
    result.minimum      = min_r;
    result.maximum      = max_r;
    result.total        = 48'(sum_r);
    result.item_total   = (cnt_x > ITW'(16'hFFFF)) ? 16'hFFFF : cnt_x[15:0];
    result.trimmed_mean = mean;
    result.status       = status_r;
  end

  assign out_valid_nxt = do_out || (out_valid_r && !out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/trimmed_mean_min_max_sum_core.sv =====
// top level: front end, run record queue and division back end
// uses tmms_pkg, tmms_front, tmms_fifo, tmms_back
//
//   channel  ports                     payload
//   input    in_push / in_full         in_item   (sample, last)
//   result   out_empty / out_pop       out_item  (min, max, total, count, mean, status)
//
// samples are taken one per cycle while the record queue has room
// each run passes through the back end's one-bit-per-cycle divider, sized by SUM_W and FRAC_BITS
// (SUM_W = 32 + clog2(MAX_ITEMS + 1)); short and overflowed runs skip the divider
// two finished runs can wait in the queue; in_full rises only when it holds both
// synchronous active-low reset clears the run state, the queue pointers, the back-end state and the result valid flag
module trimmed_mean_min_max_sum_core #(
  parameter int MAX_ITEMS = 65535,
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  tmms_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output tmms_pkg::out_item_t out_item
);
  import tmms_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = 32 + CNT_W;
  localparam int REC_W = 64 + SUM_W + CNT_W + 2;

  logic                    take;
  logic                    rec_push, rec_pop, rec_empty, rec_full;
  logic signed [31:0]      rec_min, rec_max;
  logic signed [SUM_W-1:0] rec_sum;
  logic [CNT_W-1:0]        rec_cnt;
  logic [1:0]              rec_status;
  logic [REC_W-1:0]        rec_din, rec_dout;

  assign in_full = rec_full;
  assign take    = in_push && !rec_full;
  assign rec_din = {rec_min, rec_max, rec_sum, rec_cnt, rec_status};

  tmms_front #(
    .MAX_ITEMS (MAX_ITEMS),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (in_item),
    .rec_push   (rec_push),
    .rec_min    (rec_min),
    .rec_max    (rec_max),
    .rec_sum    (rec_sum),
    .rec_cnt    (rec_cnt),
    .rec_status (rec_status)
  );

  tmms_fifo #(
    .W (REC_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .din   (rec_din),
    .full  (rec_full),
    .pop   (rec_pop),
    .dout  (rec_dout),
    .empty (rec_empty)
  );

  tmms_back #(
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .REC_W     (REC_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (rec_empty),
    .rec_data  (rec_dout),
    .rec_pop   (rec_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for trimmed_mean_min_max_sum_core: queue-style input and result channels,
// a built-in predictor of min, max, sum, count, trimmed mean and status per run
// depends on tmms_pkg and the core rtl
module tb_top;
  import tmms_pkg::*;

  localparam int RUN_CAP = 65535;
  localparam int FRAC_W = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_GAP = 13;
  localparam longint MEAN_HI = 64'sd549755813887;
  localparam longint MEAN_LO = -64'sd549755813888;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

  typedef logic signed [31:0] sample_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;

  out_item_t pending_results[$];

  // running state of the predicted run
  int unsigned acc_count;
  longint acc_min, acc_max, acc_sum;
  bit acc_over;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int rx_hold_request = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int samples_sent = 0;
  int runs_sent = 0;
  int n_ok = 0, n_short = 0, n_over = 0;
  int full_stalls = 0;

  always #10 clk = ~clk;

  trimmed_mean_min_max_sum_core #(
    .MAX_ITEMS(RUN_CAP),
    .FRAC_BITS(FRAC_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item)
  );

  function automatic bit accumulate_sample(input logic signed [31:0] smp, input logic is_last,
                                           output out_item_t res);
    longint s, num, den, q, r, m;
    logic [1:0] st;
    s = smp;
    m = 0;
    res = '0;
    if (acc_count < RUN_CAP) begin
      if (acc_count == 0) begin
        acc_min = s;
        acc_max = s;
      end else begin
        if (s < acc_min) acc_min = s;
        if (s > acc_max) acc_max = s;
      end
      acc_sum += s;
      acc_count++;
    end else begin
      acc_over = 1'b1;
    end
    if (!is_last) return 1'b0;
    if (acc_over) begin
      st = STATUS_OVER;
    end else if (acc_count < 3) begin
      st = STATUS_SHORT;
    end else begin
      st = STATUS_OK;
      num = acc_sum - acc_min - acc_max;
      den = longint'(acc_count) - 2;
      q = num / den;
      r = num % den;
      m = q * (64'sd1 <<< FRAC_W) + (r * (64'sd1 <<< FRAC_W)) / den;
      if (m > MEAN_HI) m = MEAN_HI;
      if (m < MEAN_LO) m = MEAN_LO;
    end
    res.minimum = acc_min[31:0];
    res.maximum = acc_max[31:0];
    res.total = acc_sum[47:0];
    res.item_total = (acc_count > 65535) ? 16'hffff : acc_count[15:0];
    res.trimmed_mean = m[39:0];
    res.status = st;
    acc_count = 0;
    acc_min = 0;
    acc_max = 0;
    acc_sum = 0;
    acc_over = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MIN;
      1: return S_MAX;
      2, 3: return $signed($urandom_range(0, 40)) - 32'sd20;
      default: return $urandom;
    endcase
  endfunction

  // shared item sender; leaves in_push high so back-to-back items need no gap
  task automatic push_sample(input logic signed [31:0] smp, input logic is_last);
    int gap;
    out_item_t res;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item.sample <= smp;
    in_item.last <= is_last;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    samples_sent++;
    if (accumulate_sample(smp, is_last, res)) begin
      pending_results.push_back(res);
      runs_sent++;
    end
  endtask

  task automatic wait_results_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_values(input sample_q_t vals);
    foreach (vals[i]) push_sample(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_run(input int len);
    for (int i = 1; i <= len; i++) push_sample(rand_sample(), i == len);
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t ns: result with nothing expected, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("minimum", want.minimum, got.minimum);
    compare_field("maximum", want.maximum, got.maximum);
    compare_field("total", want.total, got.total);
    compare_field("item_total", want.item_total, got.item_total);
    compare_field("trimmed_mean", want.trimmed_mean, got.trimmed_mean);
    compare_field("status", want.status, got.status);
    case (want.status)
      STATUS_OK: n_ok++;
      STATUS_SHORT: n_short++;
      default: n_over++;
    endcase
  endtask

  // result side: random pop gaps, optional long hold-off
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (rx_hold_request > 0) begin
        gap = rx_hold_request;
        rx_hold_request = 0;
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      check_result(out_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_values('{S_MIN});
    send_values('{S_MAX, S_MIN});
    send_values('{S_MIN, S_MAX, 32'sd0});
    send_values('{S_MAX, S_MAX, S_MAX});
    send_values('{S_MIN, S_MIN, S_MIN});
    // negative and positive means truncated toward zero
    send_values('{-32'sd7, -32'sd1, 32'sd0, 32'sd0, 32'sd5});
    send_values('{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd3});
    wait_results_drained();
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    wait_results_drained();
    rx_hold_request = 400;
    for (int i = 0; i < 10; i++) send_random_run(3);
    wait_results_drained();
  endtask

  task automatic test_random_runs();
    int start;
    int len;
    start = samples_sent;
    while (samples_sent - start < 1000) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_idle = 1'($urandom_range(0, 1));
        rx_idle = 1'($urandom_range(0, 1));
      end
      case ($urandom_range(0, 9))
        0: len = $urandom_range(1, 2);
        1: len = $urandom_range(20, 60);
        default: len = $urandom_range(3, 10);
      endcase
      send_random_run(len);
    end
    wait_results_drained();
  endtask

  initial begin
    acc_count = 0;
    acc_min = 0;
    acc_max = 0;
    acc_sum = 0;
    acc_over = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_backpressure();
    test_random_runs();
    wait_results_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d samples in %0d runs: %0d normal, %0d short, %0d over the cap",
             samples_sent, runs_sent, n_ok, n_short, n_over);
    $display("input held off by a full queue for %0d cycles", full_stalls);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tmms_pkg.sv
hdl/tmms_front.sv
hdl/tmms_fifo.sv
hdl/tmms_back.sv
hdl/trimmed_mean_min_max_sum_core.sv
tb/tb_top.sv
